[hdl/encoder_scan_motor_controller_unit_assert.svh]
// Assertion macros for the encoder scan motor controller unit.
// Each macro expands to one labeled concurrent assertion on clk that is
// disabled while rst_n is low.
`ifndef ENCODER_SCAN_MOTOR_CONTROLLER_UNIT_ASSERT_SVH
`define ENCODER_SCAN_MOTOR_CONTROLLER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/escm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escm_pkg
// Widths, register indexes and the stage record shared by the encoder scan
// motor controller modules.
// ----------------------------------------------------------------------------
package escm_pkg;

  localparam int ANGLE_BITS = 18;
  localparam int TURN_BITS  = 32;

  localparam int POS_W     = ANGLE_BITS + TURN_BITS;
  localparam int POS_EXT_W = (POS_W > 32) ? POS_W : 32;
  localparam int TGT_W     = ((POS_W > 19) ? POS_W : 19) + 1;
  localparam int ERR_W     = TGT_W + 1;

  localparam int IN_DATA_W  = ((ANGLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 80;

  localparam int DEADBAND_W = 17;
  localparam int GAIN_W     = 24;
  localparam int DRIVE_W    = 16;
  localparam int SWEEP_W    = 18;
  localparam int MAG_W      = 17;
  localparam int TENTHS_W   = 12;
  localparam int POS_LOW_W  = 32;
  localparam int AMAG_W     = ANGLE_BITS - 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic signed [ANGLE_BITS:0] HALF_REV =
    (ANGLE_BITS + 1)'(1) << (ANGLE_BITS - 1);
  localparam logic [MAG_W-1:0]    ERR_CAP     = 17'd65536;
  localparam logic [DRIVE_W-1:0]  DRIVE_SAT   = 16'hFFFF;
  localparam logic [11:0]         TENTHS_REV  = 12'd3600;
  localparam logic [TENTHS_W-1:0] TENTHS_HALF = 12'd1800;

  localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 17'd256;
  localparam logic [GAIN_W-1:0]     GAIN_RST      = 24'd65536;
  localparam logic [DRIVE_W-1:0]    DRIVE_MIN_RST = 16'd0;
  localparam logic [DRIVE_W-1:0]    DRIVE_MAX_RST = 16'hFFFF;
  localparam logic [SWEEP_W-1:0]    SWEEP_RST     = 18'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND   = 3'd0,
    REG_GAIN       = 3'd1,
    REG_DRIVE_MIN  = 3'd2,
    REG_DRIVE_MAX  = 3'd3,
    REG_SWEEP_HALF = 3'd4
  } cfg_reg_t;

  // Per-item record handed from the tracking stage to the output stage.
  typedef struct packed {
    logic                 homing;
    logic                 fwd_on;
    logic                 rev_on;
    logic [MAG_W-1:0]     err_mag;
    logic                 half_tie;
    logic                 ang_neg;
    logic [AMAG_W-1:0]    ang_mag;
    logic                 rel_pos;
    logic [POS_LOW_W-1:0] pos_low;
    logic                 sweep_fwd;
  } track_t;

endpackage

[hdl/encoder_scan_motor_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_scan_motor_controller_unit
// Multi-turn encoder unwrap with a proportional sweep position controller.
// Pipeline: an accepted item passes the input register, the tracking
// register and the output register in that order.
// Throughput: one item per cycle; in_tready falls only when all three
// stages hold items and the output item is not taken.
// Reset: synchronous active-low rst_n clears the pipeline, the turn count
// and the homed flag, and loads the register defaults.
// ----------------------------------------------------------------------------
module encoder_scan_motor_controller_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [17:0] raw_angle, upper bits zero
  input  logic [escm_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] drive_forward, [31:16] drive_reverse, [43:32] angle_tenths,
  // [75:44] position_low, [76] sweep_forward, [79:77] zero
  output logic [escm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [0] homing
  output logic                                out_tuser,
  input  logic                                cfg_wr_en,
  input  logic [escm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [escm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import escm_pkg::*;

  logic [DEADBAND_W-1:0] deadband_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [DRIVE_W-1:0]    drive_min_r, drive_max_r;
  logic [SWEEP_W-1:0]    sweep_half_r;

  logic                  s1_valid_r, s2_valid_r, out_valid_r;
  logic                  rdy_out, rdy_s2, rdy_s1;
  logic                  adv_s2, load_out;
  logic [ANGLE_BITS-1:0] raw_r;
  track_t                trk;

  logic [DRIVE_W-1:0]         drive_forward, drive_reverse;
  logic signed [TENTHS_W-1:0] angle_tenths;
  logic [POS_LOW_W-1:0]       position_low;
  logic                       sweep_forward, homing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r   <= DEADBAND_RST;
      gain_r       <= GAIN_RST;
      drive_min_r  <= DRIVE_MIN_RST;
      drive_max_r  <= DRIVE_MAX_RST;
      sweep_half_r <= SWEEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEADBAND:   deadband_r   <= cfg_wdata[DEADBAND_W-1:0];
        REG_GAIN:       gain_r       <= cfg_wdata[GAIN_W-1:0];
        REG_DRIVE_MIN:  drive_min_r  <= cfg_wdata[DRIVE_W-1:0];
        REG_DRIVE_MAX:  drive_max_r  <= cfg_wdata[DRIVE_W-1:0];
        REG_SWEEP_HALF: sweep_half_r <= cfg_wdata[SWEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Each stage may load when it is empty or its item moves on this cycle.
  assign rdy_out   = ~out_valid_r | out_tready;
  assign rdy_s2    = ~s2_valid_r | rdy_out;
  assign rdy_s1    = ~s1_valid_r | rdy_s2;
  assign in_tready = rdy_s1;
  assign adv_s2    = s1_valid_r & rdy_s2;
  assign load_out  = s2_valid_r & rdy_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= (in_tvalid & rdy_s1) | (s1_valid_r & ~rdy_s2);
      s2_valid_r  <= adv_s2 | (s2_valid_r & ~rdy_out);
      out_valid_r <= load_out | (out_valid_r & ~out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && rdy_s1) begin
      raw_r <= in_tdata[ANGLE_BITS-1:0];
    end
  end

  escm_track u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv_s2),
    .raw        (raw_r),
    .deadband   (deadband_r),
    .sweep_half (sweep_half_r),
    .trk_r      (trk)
  );

  escm_shape u_shape (
    .clk             (clk),
    .load            (load_out),
    .trk             (trk),
    .gain            (gain_r),
    .drive_min       (drive_min_r),
    .drive_max       (drive_max_r),
    .drive_forward_r (drive_forward),
    .drive_reverse_r (drive_reverse),
    .angle_tenths_r  (angle_tenths),
    .position_low_r  (position_low),
    .sweep_forward_r (sweep_forward),
    .homing_r        (homing)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = homing;
  assign out_tdata  = {3'b000, sweep_forward, position_low, angle_tenths,
                       drive_reverse, drive_forward};

`include "encoder_scan_motor_controller_unit_assert.svh"

  `ESCM_ASSERT_NOW(a_one_direction, out_valid_r,
    (drive_forward == '0) || (drive_reverse == '0),
    "forward and reverse drive are both active")
  `ESCM_ASSERT_NOW(a_homing_quiet, out_valid_r && homing,
    (drive_forward == '0) && (drive_reverse == '0) && (angle_tenths == '0) && !sweep_forward,
    "homing item carries drive, angle or forward sweep")
  `ESCM_ASSERT_NOW(a_angle_range, out_valid_r,
    (angle_tenths >= -$signed(TENTHS_HALF)) && (angle_tenths <= $signed(TENTHS_HALF)),
    "angle outside half revolution")
  `ESCM_ASSERT_NEXT(a_s1_hold, s1_valid_r && !rdy_s2,
    s1_valid_r && $stable(raw_r),
    "input stage lost a stalled item")
  `ESCM_ASSERT_NEXT(a_s2_hold, s2_valid_r && !rdy_out,
    s2_valid_r,
    "tracking stage lost a stalled item")

endmodule

[hdl/escm_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escm_track
// Turn counter, homing, position error and sweep direction. Updates the
// controller state for each item and registers the per-item record.
// ----------------------------------------------------------------------------
module escm_track (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic [escm_pkg::ANGLE_BITS-1:0]   raw,
  input  logic [escm_pkg::DEADBAND_W-1:0]   deadband,
  input  logic [escm_pkg::SWEEP_W-1:0]      sweep_half,
  output escm_pkg::track_t                  trk_r
);
  import escm_pkg::*;

  logic [ANGLE_BITS-1:0]       last_r;
  logic [TURN_BITS-1:0]        turn_r, turn_nxt;
  logic                        homed_r;
  logic signed [POS_W-1:0]     home_r;
  logic signed [TGT_W-1:0]     target_r;
  logic                        fwd_dir_r;

  logic signed [ANGLE_BITS:0]  diff;
  logic signed [POS_W-1:0]     pos;
  logic signed [POS_EXT_W-1:0] pos_ext;
  logic signed [ERR_W-1:0]     err, db_s;
  logic [ERR_W-1:0]            err_abs;
  logic [MAG_W-1:0]            err_cap;
  logic signed [POS_W:0]       rel;
  logic [ANGLE_BITS-1:0]       rel_lo, rel_neg;
  logic signed [TGT_W-1:0]     sweep_s, tgt_hi, tgt_lo, tgt_home;
  logic                        e_gt_db, e_lt_ndb, e_lt_db, e_gt_ndb;
  track_t                      trk_nxt;

  always_comb begin
    diff = $signed({1'b0, raw}) - $signed({1'b0, last_r});
    turn_nxt = turn_r;
    if (homed_r) begin
      if (diff < -HALF_REV) begin
        turn_nxt = turn_r + TURN_BITS'(1);
      end else if (diff > HALF_REV) begin
        turn_nxt = turn_r - TURN_BITS'(1);
      end
    end
  end

  assign pos     = $signed({turn_nxt, raw});
  assign pos_ext = POS_EXT_W'(pos);
  assign sweep_s = TGT_W'($signed({1'b0, sweep_half}));
  assign tgt_hi  = TGT_W'(home_r) + sweep_s;
  assign tgt_lo  = TGT_W'(home_r) - sweep_s;
  assign tgt_home = TGT_W'(pos) - sweep_s;

  assign err      = ERR_W'(target_r) - ERR_W'(pos);
  assign db_s     = ERR_W'($signed({1'b0, deadband}));
  assign e_gt_db  = err > db_s;
  assign e_lt_ndb = err < -db_s;
  assign e_lt_db  = err < db_s;
  assign e_gt_ndb = err > -db_s;
  assign err_abs  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign err_cap  = (err_abs > ERR_W'(ERR_CAP)) ? ERR_CAP : err_abs[MAG_W-1:0];

  // Angle from home: the low bits of the relative position, folded into
  // one signed half revolution either side.
  assign rel     = (POS_W + 1)'(pos) - (POS_W + 1)'(home_r);
  assign rel_lo  = rel[ANGLE_BITS-1:0];
  assign rel_neg = -rel_lo;

  always_comb begin
    trk_nxt           = '0;
    trk_nxt.pos_low   = pos_ext[POS_LOW_W-1:0];
    if (!homed_r) begin
      trk_nxt.homing  = 1'b1;
    end else begin
      trk_nxt.fwd_on   = e_gt_db;
      trk_nxt.rev_on   = e_lt_ndb;
      trk_nxt.err_mag  = err_cap;
      trk_nxt.half_tie = (rel_lo == HALF_REV[ANGLE_BITS-1:0]);
      trk_nxt.ang_neg  = rel_lo[ANGLE_BITS-1];
      trk_nxt.ang_mag  = rel_lo[ANGLE_BITS-1] ? rel_neg[AMAG_W-1:0] : rel_lo[AMAG_W-1:0];
      trk_nxt.rel_pos  = ~rel[POS_W];
      if (fwd_dir_r) begin
        trk_nxt.sweep_fwd = ~e_lt_db;
      end else begin
        trk_nxt.sweep_fwd = e_gt_ndb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      turn_r    <= '0;
      homed_r   <= 1'b0;
      home_r    <= '0;
      target_r  <= '0;
      fwd_dir_r <= 1'b0;
    end else if (adv) begin
      last_r <= raw;
      turn_r <= turn_nxt;
      if (!homed_r) begin
        homed_r   <= 1'b1;
        home_r    <= pos;
        target_r  <= tgt_home;
        fwd_dir_r <= 1'b0;
      end else if (fwd_dir_r && e_lt_db) begin
        fwd_dir_r <= 1'b0;
        target_r  <= tgt_lo;
      end else if (!fwd_dir_r && e_gt_ndb) begin
        fwd_dir_r <= 1'b1;
        target_r  <= tgt_hi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      trk_r <= trk_nxt;
    end
  end

endmodule

[hdl/escm_shape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escm_shape
// Output stage: scales the capped error by the gain into a limited drive
// value and converts the folded angle into tenths of a degree.
// ----------------------------------------------------------------------------
module escm_shape (
  input  logic                                clk,
  input  logic                                load,
  input  escm_pkg::track_t                    trk,
  input  logic [escm_pkg::GAIN_W-1:0]         gain,
  input  logic [escm_pkg::DRIVE_W-1:0]        drive_min,
  input  logic [escm_pkg::DRIVE_W-1:0]        drive_max,
  output logic [escm_pkg::DRIVE_W-1:0]        drive_forward_r,
  output logic [escm_pkg::DRIVE_W-1:0]        drive_reverse_r,
  output logic signed [escm_pkg::TENTHS_W-1:0] angle_tenths_r,
  output logic [escm_pkg::POS_LOW_W-1:0]      position_low_r,
  output logic                                sweep_forward_r,
  output logic                                homing_r
);
  import escm_pkg::*;

  localparam int PROD_W = MAG_W + GAIN_W;
  localparam int APROD_W = AMAG_W + 12;

  logic [PROD_W-1:0]              prod;
  logic [PROD_W-17:0]             scaled;
  logic [DRIVE_W-1:0]             sat, lim, drv;
  logic [APROD_W-1:0]             aprod;
  logic [TENTHS_W-1:0]            tmag;
  logic signed [TENTHS_W-1:0]     tenths_nxt;

  assign prod   = PROD_W'(trk.err_mag) * PROD_W'(gain);
  assign scaled = prod[PROD_W-1:16];
  assign sat    = (|scaled[PROD_W-17:DRIVE_W]) ? DRIVE_SAT : scaled[DRIVE_W-1:0];
  assign lim    = (sat > drive_max) ? drive_max : sat;
  assign drv    = (lim < drive_min) ? drive_min : lim;

  assign aprod = APROD_W'(trk.ang_mag) * APROD_W'(TENTHS_REV);
  assign tmag  = TENTHS_W'(aprod[APROD_W-1:ANGLE_BITS]);

  always_comb begin
    if (trk.half_tie) begin
      tenths_nxt = trk.rel_pos ? $signed(TENTHS_HALF) : -$signed(TENTHS_HALF);
    end else if (trk.ang_neg) begin
      tenths_nxt = -$signed(tmag);
    end else begin
      tenths_nxt = $signed(tmag);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive_forward_r <= trk.fwd_on ? drv : '0;
      drive_reverse_r <= trk.rev_on ? drv : '0;
      angle_tenths_r  <= tenths_nxt;
      position_low_r  <= trk.pos_low;
      sweep_forward_r <= trk.sweep_fwd;
      homing_r        <= trk.homing;
    end
  end

endmodule
